>>> design/qbez_pkg.sv
// Shared constants, register indexes and fixed-point helpers for the quadratic Bezier evaluator.
package qbez_pkg;

  localparam int MAX_POINTS = 64;
  localparam int T_ONE      = 32768;

  localparam int COORD_W    = 16;
  localparam int T_W        = 16;
  localparam int CNT_IN_W   = 7;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 32;

  localparam int CNT_W   = $clog2(MAX_POINTS + 1);
  localparam int DEN_W   = $clog2(MAX_POINTS);
  localparam int D2_W    = DEN_W + 1;
  localparam int DIV_NUM = 2 * T_ONE;
  localparam int DIV_W   = $clog2(DIV_NUM) + 1;
  localparam int DCNT_W  = $clog2(DIV_W);

  localparam int PROD_W  = 34;
  localparam int SUM_W   = 18;

  localparam logic [CFG_IDX_W-1:0] REG_CTRL1_X = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_CTRL1_Y = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_CTRL2_X = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_CTRL2_Y = CFG_IDX_W'(3);

  localparam logic OP_POINT = 1'b0;
  localparam logic OP_CURVE = 1'b1;

  // Rounds a Q.15 product half up and drops the fraction (floor shift).
  function automatic logic signed [SUM_W-1:0] rnd_q15(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] s;
    logic signed [PROD_W-1:0] sh;
    s  = p + PROD_W'(signed'(T_ONE / 2));
    sh = s >>> 15;
    return sh[SUM_W-1:0];
  endfunction

  // Clamps a widened coordinate to the signed Q2.14 range.
  function automatic logic [COORD_W-1:0] sat_coord(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = SUM_W'(signed'((1 << (COORD_W - 1)) - 1));
    lo = -SUM_W'(signed'(1 << (COORD_W - 1)));
    if (v > hi) begin
      return hi[COORD_W-1:0];
    end else if (v < lo) begin
      return lo[COORD_W-1:0];
    end
    return v[COORD_W-1:0];
  endfunction

endpackage

>>> design/quadratic_bezier_evaluator.sv
// Top level of the quadratic Bezier evaluator: t sequencer, step divider and lerp pipeline.
//
// This block evaluates a quadratic Bezier curve that starts at the origin, bends toward the
// middle control point (ctrl1) and ends at the end control point (ctrl2), all in signed Q2.14.
// A word with op = point (in_tuser = 0) gives one point at t_param, clamped to 1.0 and turned
// into 1 - t when reverse is set; a word with op = curve gives point_count points at evenly
// spaced t from 0 to 1, the last one with out_tlast set (a count below two gives one point at
// t = 0, a count above 64 is cut to 64). Evaluation is de Casteljau with three rounded lerps in
// a five-stage pipeline (t, first products, first lerps, second product, result); a new t can
// be issued every cycle while the output is not stalled. The input is taken while the t
// sequencer is idle; a point word occupies it until its t is issued, a curve word of N points
// while a restoring divider finds the step 65536 / (2(N-1)) and then until its last t is
// issued, each t formed by adding the step and a carried remainder. A stall on the output
// freezes the whole pipeline and holds the sequencer between t values; the step divider keeps
// running and an idle sequencer still takes a word. The user must write control registers
// via cfg_we/cfg_index/cfg_wdata only while no word is in work; the block does not enforce it.
module quadratic_bezier_evaluator
  import qbez_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [15:0] t_param, [16] reverse, [23:17] point_count
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // [0] op
  input  logic                  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [15:0] pos_x, [31:16] pos_y
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tlast,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_GEN  = 2'd2;

  // Control points.
  logic [COORD_W-1:0] p1x_r, p1y_r, p2x_r, p2y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1x_r <= '0;
      p1y_r <= '0;
      p2x_r <= COORD_W'(T_ONE / 2);
      p2y_r <= COORD_W'(T_ONE / 2);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CTRL1_X: p1x_r <= cfg_wdata[COORD_W-1:0];
        REG_CTRL1_Y: p1y_r <= cfg_wdata[COORD_W-1:0];
        REG_CTRL2_X: p2x_r <= cfg_wdata[COORD_W-1:0];
        REG_CTRL2_Y: p2y_r <= cfg_wdata[COORD_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------------------------
  // Input word fields.
  logic [T_W-1:0]      in_t;
  logic                in_rev;
  logic [CNT_IN_W-1:0] in_cnt;
  logic [T_W-1:0]      t_clamped;
  logic [T_W-1:0]      t_point;
  logic [CNT_W-1:0]    n_clamped;

  assign in_t   = in_tdata[T_W-1:0];
  assign in_rev = in_tdata[T_W];
  assign in_cnt = in_tdata[T_W+CNT_IN_W:T_W+1];

  always_comb begin
    t_clamped = (in_t > T_W'(T_ONE)) ? T_W'(T_ONE) : in_t;
    t_point   = in_rev ? (T_W'(T_ONE) - t_clamped) : t_clamped;
    n_clamped = (in_cnt > CNT_IN_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : in_cnt[CNT_W-1:0];
  end

  // ---------------------------------------------------------------------------------------------
  // t sequencer with its step divider.
  logic [1:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [T_W-1:0]    acc_q_r, acc_q_nxt;
  logic [D2_W-1:0]   acc_r_r, acc_r_nxt;
  logic [D2_W-1:0]   d2_r, d2_nxt;
  logic [D2_W-1:0]   rem_r, rem_nxt;
  logic [DIV_W-1:0]  quo_r, quo_nxt;
  logic [DCNT_W-1:0] dcnt_r, dcnt_nxt;
  logic              curve_r, curve_nxt;

  logic              adv;
  logic              issue;
  logic              issue_last;
  logic [D2_W:0]     rem_sh;
  logic              rem_ge;
  logic [D2_W:0]     acc_sum;
  logic              acc_wrap;
  logic [DEN_W-1:0]  den;

  assign in_tready  = (state_r == ST_IDLE);
  assign issue      = (state_r == ST_GEN) && adv;
  assign issue_last = (cnt_r == CNT_W'(1));

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    acc_q_nxt = acc_q_r;
    acc_r_nxt = acc_r_r;
    d2_nxt    = d2_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    dcnt_nxt  = dcnt_r;
    curve_nxt = curve_r;

    den      = DEN_W'(n_clamped - CNT_W'(1));
    // Restoring division of a power of two: only the top dividend bit is set.
    rem_sh   = {rem_r, (dcnt_r == DCNT_W'(DIV_W - 1))};
    rem_ge   = rem_sh >= {1'b0, d2_r};
    acc_sum  = {1'b0, acc_r_r} + {1'b0, rem_r};
    acc_wrap = acc_sum >= {1'b0, d2_r};

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          acc_q_nxt = '0;
          cnt_nxt   = CNT_W'(1);
          curve_nxt = 1'b0;
          state_nxt = ST_GEN;
          if (in_tuser == OP_POINT) begin
            acc_q_nxt = t_point;
          end else if (n_clamped >= CNT_W'(2)) begin
            cnt_nxt   = n_clamped;
            curve_nxt = 1'b1;
            d2_nxt    = {den, 1'b0};
            acc_r_nxt = D2_W'(den);
            rem_nxt   = '0;
            quo_nxt   = '0;
            dcnt_nxt  = DCNT_W'(DIV_W - 1);
            state_nxt = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        rem_nxt  = rem_ge ? D2_W'(rem_sh - {1'b0, d2_r}) : rem_sh[D2_W-1:0];
        quo_nxt  = {quo_r[DIV_W-2:0], rem_ge};
        dcnt_nxt = dcnt_r - DCNT_W'(1);
        if (dcnt_r == '0) begin
          state_nxt = ST_GEN;
        end
      end
      ST_GEN: begin
        if (adv) begin
          cnt_nxt   = cnt_r - CNT_W'(1);
          acc_r_nxt = acc_wrap ? D2_W'(acc_sum - {1'b0, d2_r}) : acc_sum[D2_W-1:0];
          acc_q_nxt = acc_q_r + quo_r[T_W-1:0] + T_W'(acc_wrap);
          if (issue_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      dcnt_r  <= '0;
      curve_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      dcnt_r  <= dcnt_nxt;
      curve_r <= curve_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_q_r <= acc_q_nxt;
    acc_r_r <= acc_r_nxt;
    d2_r    <= d2_nxt;
    rem_r   <= rem_nxt;
    quo_r   <= quo_nxt;
  end

  // ---------------------------------------------------------------------------------------------
  // Lerp pipeline. All stages move together; a stall on the output holds every stage.
  logic vld_a_r, vld_b_r, vld_c_r, vld_d_r, vld_e_r;
  logic lst_a_r, lst_b_r, lst_c_r, lst_d_r, lst_e_r;

  logic [T_W-1:0] t_a_r, t_b_r, t_c_r;

  logic signed [PROD_W-1:0]  pr0x_b_r, pr0y_b_r, pr1x_b_r, pr1y_b_r;
  logic signed [COORD_W-1:0] q0x_c_r, q0y_c_r, q1x_c_r, q1y_c_r;
  logic signed [COORD_W-1:0] q0x_d_r, q0y_d_r;
  logic signed [PROD_W-1:0]  pr2x_d_r, pr2y_d_r;
  logic [COORD_W-1:0]        posx_e_r, posy_e_r;

  logic signed [T_W:0]       t_a_s, t_c_s;
  logic signed [COORD_W:0]   d1x, d1y, d2x, d2y;
  logic signed [PROD_W-1:0]  pr0x_nxt, pr0y_nxt, pr1x_nxt, pr1y_nxt, pr2x_nxt, pr2y_nxt;
  logic signed [SUM_W-1:0]   q0x_sum, q0y_sum, q1x_sum, q1y_sum, rx_sum, ry_sum;

  assign adv = !vld_e_r || out_tready;

  always_comb begin
    t_a_s = signed'({1'b0, t_a_r});
    t_c_s = signed'({1'b0, t_c_r});

    d1x = (COORD_W + 1)'(signed'(p2x_r)) - (COORD_W + 1)'(signed'(p1x_r));
    d1y = (COORD_W + 1)'(signed'(p2y_r)) - (COORD_W + 1)'(signed'(p1y_r));
    pr0x_nxt = PROD_W'(signed'(p1x_r)) * PROD_W'(t_a_s);
    pr0y_nxt = PROD_W'(signed'(p1y_r)) * PROD_W'(t_a_s);
    pr1x_nxt = PROD_W'(d1x) * PROD_W'(t_a_s);
    pr1y_nxt = PROD_W'(d1y) * PROD_W'(t_a_s);

    q0x_sum = rnd_q15(pr0x_b_r);
    q0y_sum = rnd_q15(pr0y_b_r);
    q1x_sum = SUM_W'(signed'(p1x_r)) + rnd_q15(pr1x_b_r);
    q1y_sum = SUM_W'(signed'(p1y_r)) + rnd_q15(pr1y_b_r);

    d2x = (COORD_W + 1)'(q1x_c_r) - (COORD_W + 1)'(q0x_c_r);
    d2y = (COORD_W + 1)'(q1y_c_r) - (COORD_W + 1)'(q0y_c_r);
    pr2x_nxt = PROD_W'(d2x) * PROD_W'(t_c_s);
    pr2y_nxt = PROD_W'(d2y) * PROD_W'(t_c_s);

    rx_sum = SUM_W'(q0x_d_r) + rnd_q15(pr2x_d_r);
    ry_sum = SUM_W'(q0y_d_r) + rnd_q15(pr2y_d_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
      vld_b_r <= 1'b0;
      vld_c_r <= 1'b0;
      vld_d_r <= 1'b0;
      vld_e_r <= 1'b0;
    end else if (adv) begin
      vld_a_r <= issue;
      vld_b_r <= vld_a_r;
      vld_c_r <= vld_b_r;
      vld_d_r <= vld_c_r;
      vld_e_r <= vld_d_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t_a_r    <= acc_q_r;
      lst_a_r  <= issue_last;

      t_b_r    <= t_a_r;
      lst_b_r  <= lst_a_r;
      pr0x_b_r <= pr0x_nxt;
      pr0y_b_r <= pr0y_nxt;
      pr1x_b_r <= pr1x_nxt;
      pr1y_b_r <= pr1y_nxt;

      t_c_r    <= t_b_r;
      lst_c_r  <= lst_b_r;
      q0x_c_r  <= q0x_sum[COORD_W-1:0];
      q0y_c_r  <= q0y_sum[COORD_W-1:0];
      q1x_c_r  <= q1x_sum[COORD_W-1:0];
      q1y_c_r  <= q1y_sum[COORD_W-1:0];

      lst_d_r  <= lst_c_r;
      q0x_d_r  <= q0x_c_r;
      q0y_d_r  <= q0y_c_r;
      pr2x_d_r <= pr2x_nxt;
      pr2y_d_r <= pr2y_nxt;

      lst_e_r  <= lst_d_r;
      posx_e_r <= sat_coord(rx_sum);
      posy_e_r <= sat_coord(ry_sum);
    end
  end

  assign out_tvalid = vld_e_r;
  assign out_tdata  = {posy_e_r, posx_e_r};
  assign out_tlast  = lst_e_r;

  // ---------------------------------------------------------------------------------------------
  // Checks.

  // The divider leaves an exact quotient and remainder for the curve step.
  a_div_exact: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV && dcnt_r == '0) |=>
      (32'(quo_r) * 32'(d2_r) + 32'(rem_r) == 32'(DIV_NUM)) && (rem_r < d2_r))
    else $error("curve step division is not exact");

  // The last t of a curve run lands exactly on 1.0.
  a_curve_end: assert property (@(posedge clk) disable iff (!rst_n)
    (issue && issue_last && curve_r) |-> (acc_q_r == T_W'(T_ONE)))
    else $error("curve run does not end at t = 1");

  // Nothing enters the pipeline while the step is still being divided.
  a_no_issue_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV && adv) |=> !vld_a_r)
    else $error("t issued during step division");

  // A stalled output freezes the valid bits of every stage.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_e_r && !out_tready) |=>
      $stable({vld_a_r, vld_b_r, vld_c_r, vld_d_r, vld_e_r}))
    else $error("pipeline moved during an output stall");

  // The sequencer never generates with an empty count.
  a_cnt_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_GEN) |-> (cnt_r != '0))
    else $error("sequencer generating with zero points left");

endmodule

>>> sim/tb.sv
// Self-checking testbench for the quadratic Bezier evaluator under several control settings.
`timescale 1ns / 1ps

module tb;
  import qbez_pkg::*;

  // Cycles with no word moving on either side before the run is declared hung.
  // The worst honest stretch is the long output hold plus a curve divide and a sender gap.
  localparam int QUIET_LIMIT  = 4000;
  // Length of the deliberate output hold that backs the block up.
  localparam int HOLD_CYCLES  = 400;
  // Pause after the last expected point before touching the control registers.
  localparam int SETTLE       = 30;
  localparam int ITEMS_PER_SET = 65;

  // Indexes that map to no register; writes to them must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = '1;

  typedef struct packed {
    logic [COORD_W-1:0] pos_y;
    logic [COORD_W-1:0] pos_x;
    logic               last;
  } curve_point_t;

  // Holds its own copy of the control points, predicts every point a word should
  // produce and checks the points that come out in order.
  class bezier_scoreboard;
    logic signed [COORD_W-1:0] mid_x, mid_y, end_x, end_y;
    curve_point_t pending_points[$];
    int mismatches;

    function new();
      mid_x = 0;
      mid_y = 0;
      end_x = 16'sd16384;
      end_y = 16'sd16384;
      mismatches = 0;
    endfunction

    function void write_control(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_CTRL1_X: mid_x = val;
        REG_CTRL1_Y: mid_y = val;
        REG_CTRL2_X: end_x = val;
        REG_CTRL2_Y: end_y = val;
        default: ;
      endcase
    endfunction

    // a + (b - a) * t in Q1.15, rounded half up with a floor shift.
    function longint blend(longint a, longint b, longint t);
      return a + (((b - a) * t + T_ONE / 2) >>> 15);
    endfunction

    function logic [COORD_W-1:0] clamp_coord(longint v);
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v[COORD_W-1:0];
    endfunction

    function curve_point_t point_at(longint t, logic last);
      curve_point_t p;
      longint ax, ay, bx, by;
      ax = blend(0, mid_x, t);
      ay = blend(0, mid_y, t);
      bx = blend(mid_x, end_x, t);
      by = blend(mid_y, end_y, t);
      p.pos_x = clamp_coord(blend(ax, bx, t));
      p.pos_y = clamp_coord(blend(ay, by, t));
      p.last  = last;
      return p;
    endfunction

    function void note_word(logic op, logic [T_W-1:0] t, logic rev, logic [CNT_IN_W-1:0] n);
      longint tt, cnt, den;
      if (op == OP_POINT) begin
        tt = (t > T_ONE) ? T_ONE : t;
        if (rev) tt = T_ONE - tt;
        pending_points = {pending_points, point_at(tt, 1'b1)};
      end else begin
        cnt = (n > MAX_POINTS) ? MAX_POINTS : n;
        if (cnt < 2) begin
          pending_points = {pending_points, point_at(0, 1'b1)};
        end else begin
          den = cnt - 1;
          for (longint i = 0; i < cnt; i++) begin
            tt = (i * 2 * T_ONE + den) / (2 * den);
            pending_points = {pending_points, point_at(tt, i == den)};
          end
        end
      end
    endfunction

    function void check_point(logic [OUT_DATA_W-1:0] data, logic last);
      curve_point_t want;
      if (pending_points.size() == 0) begin
        if (mismatches < 10)
          $display("ERROR: point x=%h y=%h last=%b arrived with none expected",
                   data[15:0], data[31:16], last);
        mismatches++;
        return;
      end
      want = pending_points.pop_front();
      if (data[15:0] !== want.pos_x || data[31:16] !== want.pos_y || last !== want.last) begin
        if (mismatches < 10)
          $display("ERROR: expected x=%h y=%h last=%b, got x=%h y=%h last=%b",
                   want.pos_x, want.pos_y, want.last, data[15:0], data[31:16], last);
        mismatches++;
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  // [15:0] t_param, [16] reverse, [23:17] point_count
  logic [IN_DATA_W-1:0]  in_tdata;
  // [0] op
  logic                  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  // [15:0] pos_x, [31:16] pos_y
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  bezier_scoreboard sb = new();

  // Set by the stimulus to ask the output side for one long hold.
  bit hold_req = 1'b0;
  // Words left in the current sender burst.
  int burst_left = 0;

  quadratic_bezier_evaluator i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Every point that leaves the block is checked against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_tvalid && out_tready) begin
      sb.check_point(out_tdata, out_tlast);
    end
  end

  // Output side: ready follows one of three moods, picked anew for each stretch (always ready,
  // mostly ready, or a rotating 16-bit mask). When asked, it goes quiet for a long
  // stretch so the pipeline fills and the input side has to stall.
  initial begin : out_pacer
    int mood;
    logic [15:0] mask;
    forever begin
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      mood = $urandom_range(0, 2);
      mask = 16'($urandom) | 16'h0001;
      for (int k = 0; k < 64 && !hold_req; k++) begin
        case (mood)
          0: out_tready <= 1'b1;
          1: out_tready <= ($urandom_range(0, 3) != 0);
          default: out_tready <= mask[k % 16];
        endcase
        @(posedge clk);
      end
    end
  end

  // Ends the run if the block stops moving words for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
    end
    $display("FAIL quadratic_bezier_evaluator");
    $finish;
  end

  // Offers one word and holds it until the block takes it; the prediction is made
  // at the edge where the handshake happens.
  task automatic send_word(logic op, logic [T_W-1:0] t, logic rev, logic [CNT_IN_W-1:0] n);
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {n, rev, t};
    do @(posedge clk); while (!in_tready);
    sb.note_word(op, t, rev, n);
  endtask

  task automatic idle_input(int cycles);
    in_tvalid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Sender pacing: bursts of random length, sometimes a long one, with random gaps.
  task automatic pace();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      idle_input($urandom_range(1, 12));
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(0, 7);
    end
  endtask

  // Waits until every predicted point has come out and the block has settled.
  task automatic drain();
    idle_input(1);
    while (sb.pending_points.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.write_control(idx, val);
  endtask

  // Loads all four control coordinates, plus writes to unmapped indexes that
  // must be ignored.
  task automatic load_controls(logic [15:0] mx, logic [15:0] my,
                               logic [15:0] ex, logic [15:0] ey);
    write_reg(REG_SPARE_LO, 16'($urandom));
    write_reg(REG_CTRL1_X, mx);
    write_reg(REG_CTRL1_Y, my);
    write_reg(REG_CTRL2_X, ex);
    write_reg(REG_CTRL2_Y, ey);
    write_reg(REG_SPARE_HI, 16'($urandom));
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Random word: half points, half curves. Most t values lie in [0, 1], some are
  // any 16-bit value (clamped by the block), some sit on the edges. Curve counts
  // are mostly short so the run stays quick; a few go past the 64-point cap.
  task automatic random_word();
    logic op;
    logic [T_W-1:0] t;
    logic rev;
    logic [CNT_IN_W-1:0] n;
    int pick;
    op  = ($urandom_range(0, 1) == 0) ? OP_POINT : OP_CURVE;
    rev = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 7))
      0: t = 16'($urandom);
      1: begin
        pick = $urandom_range(0, 3);
        t = (pick == 0) ? 16'd0 : (pick == 1) ? 16'd1 :
            (pick == 2) ? 16'(T_ONE - 1) : 16'(T_ONE);
      end
      default: t = 16'($urandom_range(0, T_ONE));
    endcase
    pick = $urandom_range(0, 9);
    if (pick < 7) n = 7'($urandom_range(0, 8));
    else if (pick < 9) n = 7'($urandom_range(9, 32));
    else n = 7'($urandom_range(33, 127));
    send_word(op, t, rev, n);
    pace();
  endtask

  task automatic random_phase(int count);
    for (int k = 0; k < count; k++) random_word();
  endtask

  initial begin : stimulus
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= OP_POINT;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed words under the reset controls (a straight diagonal from the origin).
    // Point mode: t at zero, one, above one (clamped), halfway, reversed, and with a
    // count that must be ignored.
    send_word(OP_POINT, 16'd0, 1'b0, 7'd0);
    send_word(OP_POINT, 16'(T_ONE), 1'b0, 7'd0);
    send_word(OP_POINT, 16'hFFFF, 1'b0, 7'd127);
    send_word(OP_POINT, 16'(T_ONE + 1), 1'b0, 7'd5);
    send_word(OP_POINT, 16'd16384, 1'b0, 7'd64);
    pace();
    send_word(OP_POINT, 16'd16384, 1'b1, 7'd0);
    send_word(OP_POINT, 16'd0, 1'b1, 7'd0);
    send_word(OP_POINT, 16'hFFFF, 1'b1, 7'd0);
    send_word(OP_POINT, 16'd1, 1'b1, 7'd0);
    // Curve mode: short counts of zero and one, the smallest real curve, the cap
    // exactly, past the cap, and the widest count; t and reverse must be ignored.
    send_word(OP_CURVE, 16'hFFFF, 1'b1, 7'd0);
    send_word(OP_CURVE, 16'd0, 1'b0, 7'd1);
    send_word(OP_CURVE, 16'd12345, 1'b1, 7'd2);
    pace();
    send_word(OP_CURVE, 16'd0, 1'b0, 7'd3);
    send_word(OP_CURVE, 16'd0, 1'b0, 7'd64);
    send_word(OP_CURVE, 16'hFFFF, 1'b1, 7'd65);
    send_word(OP_CURVE, 16'd0, 1'b0, 7'd127);
    pace();
    random_phase(ITEMS_PER_SET - 16);

    // Extreme control points: bend hard one way, then the other.
    drain();
    load_controls(16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF);
    random_phase(ITEMS_PER_SET);

    // Opposite extremes, with the output held off early so the block backs up.
    drain();
    load_controls(16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000);
    hold_req = 1'b1;
    for (int k = 0; k < 12; k++) send_word(OP_CURVE, 16'($urandom), 1'($urandom), 7'd40);
    random_phase(ITEMS_PER_SET - 12);

    drain();
    load_controls(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    random_phase(ITEMS_PER_SET);

    drain();
    load_controls(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    random_phase(ITEMS_PER_SET);

    // Degenerate curve collapsed onto the origin.
    drain();
    load_controls(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    random_phase(ITEMS_PER_SET / 2);

    drain();
    load_controls(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    random_phase(ITEMS_PER_SET);

    // Let the last points out, then give stray points a chance to show up.
    drain();
    if (sb.mismatches == 0 && sb.pending_points.size() == 0) begin
      $display("PASS quadratic_bezier_evaluator");
    end else begin
      $display("FAIL quadratic_bezier_evaluator");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/qbez_pkg.sv
design/quadratic_bezier_evaluator.sv
sim/tb.sv
